// ===== rtl/slsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED scene blinker package
// Operation, scene and status codes, and the named colour table.
// ----------------------------------------------------------------------------
package slsb_pkg;

  localparam logic [2:0] OP_SCENE   = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_RGB     = 3'd2;
  localparam logic [2:0] OP_CHANNEL = 3'd3;
  localparam logic [2:0] OP_NAMED   = 3'd4;

  localparam logic [3:0] SC_IDLE        = 4'd0;
  localparam logic [3:0] SC_LISTEN      = 4'd1;
  localparam logic [3:0] SC_TTS         = 4'd2;
  localparam logic [3:0] SC_BATTERY     = 4'd3;
  localparam logic [3:0] SC_MUTE        = 4'd4;
  localparam logic [3:0] SC_OTA         = 4'd5;
  localparam logic [3:0] SC_ERROR       = 4'd6;
  localparam logic [3:0] SC_WIFI_WAIT   = 4'd7;
  localparam logic [3:0] SC_SERVER_WAIT = 4'd8;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [3:0] COLOR_INVALID = 4'd15;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_GATED  = 2'd1;
  localparam logic [1:0] ST_BADARG = 2'd2;

  localparam logic [7:0] LEVEL_FULL = 8'd255;

  // Returns {red, green, blue} of a named colour.
  function automatic logic [23:0] named_rgb(input logic [3:0] ci);
    logic [23:0] c;
    unique case (ci)
      4'd0:    c = {8'd255, 8'd0,   8'd0};
      4'd1:    c = {8'd0,   8'd255, 8'd0};
      4'd2:    c = {8'd0,   8'd0,   8'd255};
      4'd3:    c = {8'd255, 8'd255, 8'd0};
      4'd4:    c = {8'd0,   8'd255, 8'd255};
      4'd5:    c = {8'd0,   8'd204, 8'd204};
      4'd6:    c = {8'd255, 8'd0,   8'd255};
      4'd7:    c = {8'd255, 8'd255, 8'd255};
      4'd8:    c = {8'd255, 8'd102, 8'd0};
      4'd9:    c = {8'd153, 8'd0,   8'd255};
      4'd10:   c = {8'd102, 8'd0,   8'd204};
      4'd11:   c = {8'd255, 8'd51,  8'd102};
      4'd12:   c = {8'd255, 8'd153, 8'd51};
      4'd13:   c = {8'd51,  8'd153, 8'd255};
      4'd14:   c = {8'd128, 8'd255, 8'd0};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/slsb_scale_unit.sv =====
// ----------------------------------------------------------------------------
// Shared scaling unit
// Registers a*b on enable; q gives floor(product/255) from that register.
// ----------------------------------------------------------------------------
module slsb_scale_unit (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] q
);

  logic [15:0] prod_r;
  logic [15:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {8'd0, a} * {8'd0, b};
    end
  end

  // The product never exceeds 255*255, so the sum stays within 16 bits.
  assign sum = prod_r + {8'd0, prod_r[15:8]} + 16'd1;
  assign q   = sum[15:8];

endmodule

// ===== rtl/status_led_scene_blinker.sv =====
// ----------------------------------------------------------------------------
// Status LED scene blinker
// A result is registered after its item steps through the three duty scalings and
// the final step, with three colour scalings first for a named colour. A new item
// is taken the cycle after the result is registered, so items never overlap, as all
// scalings share one multiplier. A stalled result holds the next item in its final step until the result is taken.
// Synchronous active-low reset clears levels, scene, blink state and sets the
// global brightness to full.
// ----------------------------------------------------------------------------
module status_led_scene_blinker
  import slsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [3:0] in_scene,
  input  logic       in_battery_low,
  input  logic       in_muted,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [1:0] in_channel_select,
  input  logic [7:0] in_channel_level,
  input  logic [3:0] in_color_index,
  input  logic [7:0] in_intensity,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_duty_red,
  output logic [7:0] out_duty_green,
  output logic [7:0] out_duty_blue,
  output logic [3:0] out_current_scene,
  output logic       out_blink_phase_on,
  output logic [1:0] out_status
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_NAMED = 4'b0010,
    S_DUTY  = 4'b0100,
    S_LAST  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_LVL_R,
    DST_LVL_G,
    DST_LVL_B,
    DST_DUTY_R,
    DST_DUTY_G,
    DST_DUTY_B
  } dst_t;

  state_t     state_r, state_nxt;
  dst_t       dst_r, dst_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] bright_r, bright_nxt;
  logic [7:0] lvl_red_r, lvl_red_nxt;
  logic [7:0] lvl_green_r, lvl_green_nxt;
  logic [7:0] lvl_blue_r, lvl_blue_nxt;
  logic [3:0] scene_r, scene_nxt;
  logic       act_r, act_nxt;
  logic       lit_r, lit_nxt;
  logic [7:0] bc_red_r, bc_red_nxt;
  logic [7:0] bc_green_r, bc_green_nxt;
  logic [7:0] bc_blue_r, bc_blue_nxt;
  logic [1:0] status_r, status_nxt;
  logic [3:0] ci_r, ci_nxt;
  logic [7:0] inten_r, inten_nxt;
  logic [7:0] duty_red_r, duty_red_nxt;
  logic [7:0] duty_green_r, duty_green_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] o_red_r, o_red_nxt;
  logic [7:0] o_green_r, o_green_nxt;
  logic [7:0] o_blue_r, o_blue_nxt;
  logic [3:0] o_scene_r, o_scene_nxt;
  logic       o_phase_r, o_phase_nxt;
  logic [1:0] o_status_r, o_status_nxt;

  logic        accept;
  logic        gated;
  logic        issue_en;
  logic [7:0]  op_a, op_b;
  logic [7:0]  q;
  logic [23:0] named_c;

  slsb_scale_unit u_scale (
    .clk (clk),
    .en  (issue_en),
    .a   (op_a),
    .b   (op_b),
    .q   (q)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign named_c  = named_rgb(ci_r);
  assign gated    = (in_battery_low && (in_scene != SC_BATTERY)) ||
                    (in_muted && (in_scene != SC_MUTE) && (in_scene != SC_BATTERY));

  always_comb begin
    state_nxt      = state_r;
    dst_nxt        = DST_NONE;
    cnt_nxt        = cnt_r;
    bright_nxt     = cfg_wr_en ? cfg_wr_data : bright_r;
    lvl_red_nxt    = lvl_red_r;
    lvl_green_nxt  = lvl_green_r;
    lvl_blue_nxt   = lvl_blue_r;
    scene_nxt      = scene_r;
    act_nxt        = act_r;
    lit_nxt        = lit_r;
    bc_red_nxt     = bc_red_r;
    bc_green_nxt   = bc_green_r;
    bc_blue_nxt    = bc_blue_r;
    status_nxt     = status_r;
    ci_nxt         = ci_r;
    inten_nxt      = inten_r;
    duty_red_nxt   = duty_red_r;
    duty_green_nxt = duty_green_r;
    out_valid_nxt  = out_valid_r && out_stall;
    o_red_nxt      = o_red_r;
    o_green_nxt    = o_green_r;
    o_blue_nxt     = o_blue_r;
    o_scene_nxt    = o_scene_r;
    o_phase_nxt    = o_phase_r;
    o_status_nxt   = o_status_r;
    issue_en       = 1'b0;
    op_a           = 8'd0;
    op_b           = 8'd0;

    unique case (dst_r)
      DST_LVL_R:  lvl_red_nxt    = q;
      DST_LVL_G:  lvl_green_nxt  = q;
      DST_LVL_B:  lvl_blue_nxt   = q;
      DST_DUTY_R: duty_red_nxt   = q;
      DST_DUTY_G: duty_green_nxt = q;
      default: begin
      end
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_DONE;
          state_nxt  = S_DUTY;
          cnt_nxt    = 2'd0;
          unique case (in_operation)
            OP_SCENE: begin
              if (gated) begin
                status_nxt = ST_GATED;
              end else begin
                act_nxt   = 1'b0;
                scene_nxt = in_scene;
                unique case (in_scene)
                  SC_IDLE: begin
                    {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = 24'd0;
                  end
                  SC_LISTEN: begin
                    {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = {16'd0, LEVEL_FULL};
                  end
                  SC_TTS: begin
                    {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = {8'd0, LEVEL_FULL, 8'd0};
                  end
                  SC_MUTE, SC_ERROR: begin
                    {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = {LEVEL_FULL, 16'd0};
                  end
                  SC_OTA: begin
                    {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = {8'd153, 8'd0, LEVEL_FULL};
                  end
                  SC_BATTERY, SC_WIFI_WAIT, SC_SERVER_WAIT: begin
                    priority if (in_scene == SC_BATTERY) begin
                      {bc_red_nxt, bc_green_nxt, bc_blue_nxt} = {LEVEL_FULL, 16'd0};
                    end else if (in_scene == SC_WIFI_WAIT) begin
                      {bc_red_nxt, bc_green_nxt, bc_blue_nxt} =
                        {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
                    end else begin
                      {bc_red_nxt, bc_green_nxt, bc_blue_nxt} = {8'd0, LEVEL_FULL, 8'd0};
                    end
                    act_nxt       = 1'b1;
                    lit_nxt       = 1'b1;
                    lvl_red_nxt   = bc_red_nxt;
                    lvl_green_nxt = bc_green_nxt;
                    lvl_blue_nxt  = bc_blue_nxt;
                  end
                  default: status_nxt = ST_BADARG;
                endcase
              end
            end
            OP_TICK: begin
              if (act_r) begin
                lit_nxt = !lit_r;
                if (!lit_r) begin
                  {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} =
                    {bc_red_r, bc_green_r, bc_blue_r};
                end else begin
                  {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = 24'd0;
                end
              end
            end
            OP_RGB: begin
              {lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt} = {in_red, in_green, in_blue};
            end
            OP_CHANNEL: begin
              unique case (in_channel_select)
                CH_RED:   lvl_red_nxt   = in_channel_level;
                CH_GREEN: lvl_green_nxt = in_channel_level;
                CH_BLUE:  lvl_blue_nxt  = in_channel_level;
                default:  status_nxt    = ST_BADARG;
              endcase
            end
            OP_NAMED: begin
              if (in_color_index == COLOR_INVALID) begin
                status_nxt = ST_BADARG;
              end else begin
                ci_nxt    = in_color_index;
                inten_nxt = in_intensity;
                state_nxt = S_NAMED;
              end
            end
            default: status_nxt = ST_BADARG;
          endcase
        end
      end
      S_NAMED: begin
        issue_en = 1'b1;
        op_b     = inten_r;
        unique case (cnt_r)
          2'd0: begin
            op_a    = named_c[23:16];
            dst_nxt = DST_LVL_R;
          end
          2'd1: begin
            op_a    = named_c[15:8];
            dst_nxt = DST_LVL_G;
          end
          default: begin
            op_a    = named_c[7:0];
            dst_nxt = DST_LVL_B;
          end
        endcase
        if (cnt_r == 2'd2) begin
          state_nxt = S_DUTY;
          cnt_nxt   = 2'd0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_DUTY: begin
        issue_en = 1'b1;
        op_b     = bright_r;
        unique case (cnt_r)
          2'd0: begin
            op_a    = lvl_red_r;
            dst_nxt = DST_DUTY_R;
          end
          2'd1: begin
            op_a    = lvl_green_r;
            dst_nxt = DST_DUTY_G;
          end
          default: begin
            op_a    = lvl_blue_r;
            dst_nxt = DST_DUTY_B;
          end
        endcase
        if (cnt_r == 2'd2) begin
          state_nxt = S_LAST;
          cnt_nxt   = 2'd0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_LAST: begin
        dst_nxt = dst_r;
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          o_red_nxt     = duty_red_r;
          o_green_nxt   = duty_green_r;
          o_blue_nxt    = q;
          o_scene_nxt   = scene_r;
          o_phase_nxt   = act_r && lit_r;
          o_status_nxt  = status_r;
          dst_nxt       = DST_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dst_r       <= DST_NONE;
      cnt_r       <= 2'd0;
      bright_r    <= LEVEL_FULL;
      lvl_red_r   <= 8'd0;
      lvl_green_r <= 8'd0;
      lvl_blue_r  <= 8'd0;
      scene_r     <= SC_IDLE;
      act_r       <= 1'b0;
      lit_r       <= 1'b0;
      bc_red_r    <= 8'd0;
      bc_green_r  <= 8'd0;
      bc_blue_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_r       <= dst_nxt;
      cnt_r       <= cnt_nxt;
      bright_r    <= bright_nxt;
      lvl_red_r   <= lvl_red_nxt;
      lvl_green_r <= lvl_green_nxt;
      lvl_blue_r  <= lvl_blue_nxt;
      scene_r     <= scene_nxt;
      act_r       <= act_nxt;
      lit_r       <= lit_nxt;
      bc_red_r    <= bc_red_nxt;
      bc_green_r  <= bc_green_nxt;
      bc_blue_r   <= bc_blue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    ci_r         <= ci_nxt;
    inten_r      <= inten_nxt;
    duty_red_r   <= duty_red_nxt;
    duty_green_r <= duty_green_nxt;
    o_red_r      <= o_red_nxt;
    o_green_r    <= o_green_nxt;
    o_blue_r     <= o_blue_nxt;
    o_scene_r    <= o_scene_nxt;
    o_phase_r    <= o_phase_nxt;
    o_status_r   <= o_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_duty_red       = o_red_r;
  assign out_duty_green     = o_green_r;
  assign out_duty_blue      = o_blue_r;
  assign out_current_scene  = o_scene_r;
  assign out_blink_phase_on = o_phase_r;
  assign out_status         = o_status_r;

`ifndef SYNTH
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_NAMED || state_r == S_DUTY))
    else $error("accepted item did not start the sequencer");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LAST))
    else $error("result raised outside the final step");

  a_last_capture_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (dst_r == DST_DUTY_B) |-> (state_r == S_LAST))
    else $error("blue duty capture outside the final step");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(o_blue_r) && $stable(o_status_r)))
    else $error("stalled result was overwritten");
`endif

endmodule

// ===== tb/status_led_scene_blinker_test.sv =====
// ----------------------------------------------------------------------------
// Status LED scene blinker testbench
// A driver and a monitor check every result against a predictor of the levels,
// scene and blink state, over directed and random items at several brightness
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module status_led_scene_blinker_test;
  import slsb_pkg::*;

  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          RANDOM_PER_STEP = 285;
  localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;
  localparam logic [3:0]  SC_BAD_FIRST    = 4'd9;
  localparam logic [3:0]  SC_BAD_LAST     = 4'd15;
  localparam logic [1:0]  CH_INVALID      = 2'd3;
  localparam logic [3:0]  COLOR_LAST      = 4'd14;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] scene;
    logic       battery_low;
    logic       muted;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] channel_select;
    logic [7:0] channel_level;
    logic [3:0] color_index;
    logic [7:0] intensity;
  } led_item_t;

  typedef struct packed {
    logic [7:0] duty_red;
    logic [7:0] duty_green;
    logic [7:0] duty_blue;
    logic [3:0] current_scene;
    logic       blink_phase_on;
    logic [1:0] status;
  } led_duty_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_operation = 3'd0;
  logic [3:0] in_scene = 4'd0;
  logic       in_battery_low = 1'b0;
  logic       in_muted = 1'b0;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic [1:0] in_channel_select = 2'd0;
  logic [7:0] in_channel_level = 8'd0;
  logic [3:0] in_color_index = 4'd0;
  logic [7:0] in_intensity = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_duty_red;
  logic [7:0] out_duty_green;
  logic [7:0] out_duty_blue;
  logic [3:0] out_current_scene;
  logic       out_blink_phase_on;
  logic [1:0] out_status;

  status_led_scene_blinker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_scene           (in_scene),
    .in_battery_low     (in_battery_low),
    .in_muted           (in_muted),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_channel_select  (in_channel_select),
    .in_channel_level   (in_channel_level),
    .in_color_index     (in_color_index),
    .in_intensity       (in_intensity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_duty_red       (out_duty_red),
    .out_duty_green     (out_duty_green),
    .out_duty_blue      (out_duty_blue),
    .out_current_scene  (out_current_scene),
    .out_blink_phase_on (out_blink_phase_on),
    .out_status         (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the light.
  logic [7:0] lvl_red = 8'd0, lvl_green = 8'd0, lvl_blue = 8'd0;
  logic [7:0] flash_red = 8'd0, flash_green = 8'd0, flash_blue = 8'd0;
  logic [3:0] scene_now = SC_IDLE;
  logic       flashing = 1'b0;
  logic       flash_lit = 1'b0;
  logic [7:0] brightness = LEVEL_FULL;

  led_item_t  pending_q[$];
  led_duty_t  duty_expect_q[$];
  int         issued_count = 0;
  int         results_seen = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  logic       in_taken = 1'b0;
  int         gap_left = 0;
  int         in_calm = 0;
  int         stall_left = 0;
  int         out_calm = 0;

  function automatic logic [7:0] scale255(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = {8'd0, a} * {8'd0, b};
    return 8'(prod / 16'd255);
  endfunction

  function automatic logic [23:0] colour_rgb(input logic [3:0] idx);
    case (idx)
      4'd0:    return {8'd255, 8'd0,   8'd0};
      4'd1:    return {8'd0,   8'd255, 8'd0};
      4'd2:    return {8'd0,   8'd0,   8'd255};
      4'd3:    return {8'd255, 8'd255, 8'd0};
      4'd4:    return {8'd0,   8'd255, 8'd255};
      4'd5:    return {8'd0,   8'd204, 8'd204};
      4'd6:    return {8'd255, 8'd0,   8'd255};
      4'd7:    return {8'd255, 8'd255, 8'd255};
      4'd8:    return {8'd255, 8'd102, 8'd0};
      4'd9:    return {8'd153, 8'd0,   8'd255};
      4'd10:   return {8'd102, 8'd0,   8'd204};
      4'd11:   return {8'd255, 8'd51,  8'd102};
      4'd12:   return {8'd255, 8'd153, 8'd51};
      4'd13:   return {8'd51,  8'd153, 8'd255};
      4'd14:   return {8'd128, 8'd255, 8'd0};
      default: return 24'd0;
    endcase
  endfunction

  function automatic void set_levels(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    lvl_red   = r;
    lvl_green = g;
    lvl_blue  = b;
  endfunction

  function automatic void start_flash(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    flash_red   = r;
    flash_green = g;
    flash_blue  = b;
    flashing    = 1'b1;
    flash_lit   = 1'b1;
    set_levels(r, g, b);
  endfunction

  function automatic led_duty_t predict_duties(input led_item_t it);
    led_duty_t  res;
    logic [1:0] st;
    logic [23:0] rgb;
    st = ST_DONE;
    case (it.operation)
      OP_SCENE: begin
        if (it.battery_low && it.scene != SC_BATTERY) begin
          st = ST_GATED;
        end else if (it.muted && it.scene != SC_MUTE && it.scene != SC_BATTERY) begin
          st = ST_GATED;
        end else begin
          flashing  = 1'b0;
          scene_now = it.scene;
          case (it.scene)
            SC_IDLE:        set_levels(8'd0, 8'd0, 8'd0);
            SC_LISTEN:      set_levels(8'd0, 8'd0, 8'd255);
            SC_TTS:         set_levels(8'd0, 8'd255, 8'd0);
            SC_BATTERY:     start_flash(8'd255, 8'd0, 8'd0);
            SC_MUTE:        set_levels(8'd255, 8'd0, 8'd0);
            SC_OTA:         set_levels(8'd153, 8'd0, 8'd255);
            SC_ERROR:       set_levels(8'd255, 8'd0, 8'd0);
            SC_WIFI_WAIT:   start_flash(8'd255, 8'd255, 8'd255);
            SC_SERVER_WAIT: start_flash(8'd0, 8'd255, 8'd0);
            default:        st = ST_BADARG;
          endcase
        end
      end
      OP_TICK: begin
        if (flashing) begin
          flash_lit = !flash_lit;
          if (flash_lit) set_levels(flash_red, flash_green, flash_blue);
          else set_levels(8'd0, 8'd0, 8'd0);
        end
      end
      OP_RGB: set_levels(it.red, it.green, it.blue);
      OP_CHANNEL: begin
        case (it.channel_select)
          CH_RED:   lvl_red = it.channel_level;
          CH_GREEN: lvl_green = it.channel_level;
          CH_BLUE:  lvl_blue = it.channel_level;
          default:  st = ST_BADARG;
        endcase
      end
      OP_NAMED: begin
        if (it.color_index == COLOR_INVALID) begin
          st = ST_BADARG;
        end else begin
          rgb = colour_rgb(it.color_index);
          set_levels(scale255(rgb[23:16], it.intensity), scale255(rgb[15:8], it.intensity),
                     scale255(rgb[7:0], it.intensity));
        end
      end
      default: st = ST_BADARG;
    endcase
    res.duty_red       = scale255(lvl_red, brightness);
    res.duty_green     = scale255(lvl_green, brightness);
    res.duty_blue      = scale255(lvl_blue, brightness);
    res.current_scene  = scene_now;
    res.blink_phase_on = flashing && flash_lit;
    res.status         = st;
    return res;
  endfunction

  function automatic logic [7:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic led_item_t rand_item();
    led_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) it.operation = OP_SCENE;
    else if (r < 45) it.operation = OP_TICK;
    else if (r < 60) it.operation = OP_RGB;
    else if (r < 75) it.operation = OP_CHANNEL;
    else if (r < 95) it.operation = OP_NAMED;
    else it.operation = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    if ($urandom_range(0, 9) == 0) it.scene = 4'($urandom_range(SC_BAD_FIRST, SC_BAD_LAST));
    else it.scene = 4'($urandom_range(SC_IDLE, SC_SERVER_WAIT));
    it.battery_low = ($urandom_range(0, 4) == 0);
    it.muted       = ($urandom_range(0, 4) == 0);
    it.red         = rand_level();
    it.green       = rand_level();
    it.blue        = rand_level();
    if ($urandom_range(0, 9) == 0) it.channel_select = CH_INVALID;
    else it.channel_select = 2'($urandom_range(CH_RED, CH_BLUE));
    it.channel_level = rand_level();
    if ($urandom_range(0, 14) == 0) it.color_index = COLOR_INVALID;
    else it.color_index = 4'($urandom_range(0, COLOR_LAST));
    it.intensity = rand_level();
    return it;
  endfunction

  function automatic led_item_t op_item(input logic [2:0] op);
    led_item_t it;
    it = rand_item();
    it.operation = op;
    return it;
  endfunction

  function automatic led_item_t scene_item(input logic [3:0] sc, input logic batt,
                                           input logic mute);
    led_item_t it;
    it = op_item(OP_SCENE);
    it.scene       = sc;
    it.battery_low = batt;
    it.muted       = mute;
    return it;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_item(input led_item_t it);
    pending_q.push_back(it);
    issued_count++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (results_seen != issued_count) @(negedge clk);
  endtask

  task automatic write_brightness(input logic [7:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Driver: presents the next pending item, holds it while stalled.
  always @(negedge clk) begin
    led_item_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_q.size() > 0) begin
      cur = pending_q.pop_front();
      in_operation      <= cur.operation;
      in_scene          <= cur.scene;
      in_battery_low    <= cur.battery_low;
      in_muted          <= cur.muted;
      in_red            <= cur.red;
      in_green          <= cur.green;
      in_blue           <= cur.blue;
      in_channel_select <= cur.channel_select;
      in_channel_level  <= cur.channel_level;
      in_color_index    <= cur.color_index;
      in_intensity      <= cur.intensity;
      in_valid          <= 1'b1;
      gap_left = pick_gap(in_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap(out_calm);
    end
  end

  // Monitor: checks results in order and predicts each accepted item.
  always @(posedge clk) begin
    led_item_t it;
    led_duty_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      if (cfg_wr_en) brightness = cfg_wr_data;
      in_taken <= rst_n && in_valid && !in_stall;
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, -1);
        end else begin
          want = duty_expect_q.pop_front();
          if (out_duty_red !== want.duty_red)
            report_mismatch("duty_red", out_duty_red, want.duty_red);
          if (out_duty_green !== want.duty_green)
            report_mismatch("duty_green", out_duty_green, want.duty_green);
          if (out_duty_blue !== want.duty_blue)
            report_mismatch("duty_blue", out_duty_blue, want.duty_blue);
          if (out_current_scene !== want.current_scene)
            report_mismatch("current_scene", out_current_scene, want.current_scene);
          if (out_blink_phase_on !== want.blink_phase_on)
            report_mismatch("blink_phase_on", out_blink_phase_on, want.blink_phase_on);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      if (rst_n && in_valid && !in_stall) begin
        it.operation      = in_operation;
        it.scene          = in_scene;
        it.battery_low    = in_battery_low;
        it.muted          = in_muted;
        it.red            = in_red;
        it.green          = in_green;
        it.blue           = in_blue;
        it.channel_select = in_channel_select;
        it.channel_level  = in_channel_level;
        it.color_index    = in_color_index;
        it.intensity      = in_intensity;
        duty_expect_q.push_back(predict_duties(it));
      end
    end
  end

  initial begin
    led_item_t it;
    logic [7:0] steps[6];
    steps = '{8'd0, 8'd1, 8'd128, 8'd0, 8'd254, 8'd255};
    steps[3] = 8'($urandom_range(2, 253));

    queue_item(op_item(OP_TICK));
    for (int sc = SC_IDLE; sc <= SC_SERVER_WAIT; sc++)
      queue_item(scene_item(4'(sc), 1'b0, 1'b0));
    queue_item(op_item(OP_TICK));
    queue_item(op_item(OP_TICK));
    it = op_item(OP_RGB);
    it.red   = 8'd255;
    it.green = 8'd255;
    it.blue  = 8'd255;
    queue_item(it);
    queue_item(op_item(OP_TICK));
    queue_item(scene_item(SC_BAD_FIRST, 1'b0, 1'b0));
    queue_item(scene_item(SC_BAD_LAST, 1'b0, 1'b0));
    queue_item(scene_item(SC_LISTEN, 1'b1, 1'b0));
    queue_item(scene_item(SC_BATTERY, 1'b1, 1'b1));
    queue_item(scene_item(SC_TTS, 1'b0, 1'b1));
    queue_item(scene_item(SC_MUTE, 1'b0, 1'b1));
    it = op_item(OP_CHANNEL);
    it.channel_select = CH_INVALID;
    queue_item(it);
    it = op_item(OP_CHANNEL);
    it.channel_select = CH_BLUE;
    it.channel_level  = 8'd255;
    queue_item(it);
    it = op_item(OP_NAMED);
    it.color_index = COLOR_INVALID;
    queue_item(it);
    it = op_item(OP_NAMED);
    it.color_index = COLOR_LAST;
    it.intensity   = 8'd255;
    queue_item(it);
    queue_item(op_item(OP_UNUSED_FIRST));
    queue_item(op_item(OP_UNUSED_LAST));
    for (int n = 0; n < RANDOM_PER_STEP; n++) queue_item(rand_item());

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[s]) begin
      write_brightness(steps[s]);
      for (int n = 0; n < RANDOM_PER_STEP; n++) queue_item(rand_item());
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (duty_expect_q.size() != 0)
      report_mismatch("results outstanding", 0, duty_expect_q.size());
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slsb_pkg.sv
rtl/slsb_scale_unit.sv
rtl/status_led_scene_blinker.sv
tb/status_led_scene_blinker_test.sv
